@@ src/apu_pkg.sv @@
`default_nettype none

package apu_pkg;

    localparam int unsigned NUM_CHAN = 3;

    // opcodes
    localparam logic OP_PREMUL   = 1'b0;
    localparam logic OP_UNPREMUL = 1'b1;

    localparam logic [7:0]  ALPHA_ZERO = 8'h00;
    localparam logic [7:0]  ALPHA_FULL = 8'hff;
    localparam logic [16:0] ROUND_BIAS = 17'h00080;

    typedef logic [7:0]  t_chan;
    typedef logic [23:0] t_factor;
    typedef logic [31:0] t_prod;

    // stage 1 to stage 2
    typedef struct packed {
        logic        op;
        logic        pass;
        logic        clear;
        logic [31:0] pixel;
        t_factor     factor;
    } t_s1;

    // stage 2 to stage 3
    typedef struct packed {
        logic                       op;
        logic                       pass;
        logic                       clear;
        logic [31:0]                pixel;
        logic [NUM_CHAN-1:0][31:0]  prod;
    } t_s2;

    // floor(65536*255/alpha), entry 0 unused
    localparam t_factor RECIP_ROM [0:255] = '{
        24'h000000,24'hff0000,24'h7f8000,24'h550000,24'h3fc000,24'h330000,24'h2a8000,24'h246db6,
        24'h1fe000,24'h1c5555,24'h198000,24'h172e8b,24'h154000,24'h139d89,24'h1236db,24'h110000,
        24'h0ff000,24'h0f0000,24'h0e2aaa,24'h0d6bca,24'h0cc000,24'h0c2492,24'h0b9745,24'h0b1642,
        24'h0aa000,24'h0a3333,24'h09cec4,24'h0971c7,24'h091b6d,24'h08cb08,24'h088000,24'h0839ce,
        24'h07f800,24'h07ba2e,24'h078000,24'h074924,24'h071555,24'h06e453,24'h06b5e5,24'h0689d8,
        24'h066000,24'h063831,24'h061249,24'h05ee23,24'h05cba2,24'h05aaaa,24'h058b21,24'h056cef,
        24'h055000,24'h05343e,24'h051999,24'h050000,24'h04e762,24'h04cfb2,24'h04b8e3,24'h04a2e8,
        24'h048db6,24'h047943,24'h046584,24'h045270,24'h044000,24'h042e29,24'h041ce7,24'h040c30,
        24'h03fc00,24'h03ec4e,24'h03dd17,24'h03ce54,24'h03c000,24'h03b216,24'h03a492,24'h03976f,
        24'h038aaa,24'h037e3f,24'h037229,24'h036666,24'h035af2,24'h034fca,24'h0344ec,24'h033a54,
        24'h033000,24'h0325ed,24'h031c18,24'h031281,24'h030924,24'h030000,24'h02f711,24'h02ee58,
        24'h02e5d1,24'h02dd7b,24'h02d555,24'h02cd5c,24'h02c590,24'h02bdef,24'h02b677,24'h02af28,
        24'h02a800,24'h02a0fd,24'h029a1f,24'h029364,24'h028ccc,24'h028656,24'h028000,24'h0279c9,
        24'h0273b1,24'h026db6,24'h0267d9,24'h026217,24'h025c71,24'h0256e6,24'h025174,24'h024c1b,
        24'h0246db,24'h0241b2,24'h023ca1,24'h0237a6,24'h0232c2,24'h022df2,24'h022938,24'h022492,
        24'h022000,24'h021b81,24'h021714,24'h0212bb,24'h020e73,24'h020a3d,24'h020618,24'h020204,
        24'h01fe00,24'h01fa0b,24'h01f627,24'h01f252,24'h01ee8b,24'h01ead3,24'h01e72a,24'h01e38e,
        24'h01e000,24'h01dc7f,24'h01d90b,24'h01d5a3,24'h01d249,24'h01cefa,24'h01cbb7,24'h01c880,
        24'h01c555,24'h01c234,24'h01bf1f,24'h01bc14,24'h01b914,24'h01b61e,24'h01b333,24'h01b051,
        24'h01ad79,24'h01aaaa,24'h01a7e5,24'h01a529,24'h01a276,24'h019fcb,24'h019d2a,24'h019a90,
        24'h019800,24'h019577,24'h0192f6,24'h01907d,24'h018e0c,24'h018ba2,24'h018940,24'h0186e5,
        24'h018492,24'h018245,24'h018000,24'h017dc1,24'h017b88,24'h017957,24'h01772c,24'h017507,
        24'h0172e8,24'h0170d0,24'h016ebd,24'h016cb1,24'h016aaa,24'h0168a9,24'h0166ae,24'h0164b8,
        24'h0162c8,24'h0160dd,24'h015ef7,24'h015d17,24'h015b3b,24'h015965,24'h015794,24'h0155c7,
        24'h015400,24'h01523d,24'h01507e,24'h014ec4,24'h014d0f,24'h014b5e,24'h0149b2,24'h01480a,
        24'h014666,24'h0144c6,24'h01432b,24'h014193,24'h014000,24'h013e70,24'h013ce4,24'h013b5c,
        24'h0139d8,24'h013858,24'h0136db,24'h013562,24'h0133ec,24'h01327a,24'h01310b,24'h012fa0,
        24'h012e38,24'h012cd4,24'h012b73,24'h012a15,24'h0128ba,24'h012762,24'h01260d,24'h0124bc,
        24'h01236d,24'h012222,24'h0120d9,24'h011f93,24'h011e50,24'h011d10,24'h011bd3,24'h011a98,
        24'h011961,24'h01182b,24'h0116f9,24'h0115c9,24'h01149c,24'h011371,24'h011249,24'h011123,
        24'h011000,24'h010edf,24'h010dc0,24'h010ca4,24'h010b8a,24'h010a72,24'h01095d,24'h01084a,
        24'h010739,24'h01062b,24'h01051e,24'h010414,24'h01030c,24'h010206,24'h010102,24'h010000
    };

endpackage

`default_nettype wire

@@ src/apu_lookup.sv @@
`default_nettype none

module apu_lookup
    import apu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_opcode,
    input  wire logic [31:0] i_pixel,
    output      logic        o_valid,
    output      t_s1         o_s1
);

    logic  r_valid;
    t_s1   r_s1;
    t_s1   n_s1;
    t_chan alpha;

    assign alpha = i_pixel[31:24];

    always_comb begin
        n_s1       = '0;
        n_s1.op    = i_opcode;
        n_s1.pixel = i_pixel;
        if (i_opcode == OP_UNPREMUL) begin
            n_s1.pass   = (alpha == ALPHA_ZERO) || (alpha == ALPHA_FULL);
            n_s1.clear  = 1'b0;
            n_s1.factor = RECIP_ROM[alpha];
        end else begin
            n_s1.pass   = (alpha == ALPHA_FULL);
            n_s1.clear  = (alpha == ALPHA_ZERO);
            // premultiply scales by alpha itself
            n_s1.factor = {16'h0000, alpha};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

`default_nettype wire

@@ src/apu_mult.sv @@
`default_nettype none

module apu_mult
    import apu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_s1  i_s1,
    output      logic o_valid,
    output      t_s2  o_s2
);

    logic r_valid;
    t_s2  r_s2;
    t_s2  n_s2;

    always_comb begin
        n_s2.op    = i_s1.op;
        n_s2.pass  = i_s1.pass;
        n_s2.clear = i_s1.clear;
        n_s2.pixel = i_s1.pixel;
        // one 8 x 24 multiplier per colour channel
        for (int k = 0; k < NUM_CHAN; k++) begin
            n_s2.prod[k] = 32'(i_s1.pixel[k*8 +: 8]) * 32'(i_s1.factor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

`default_nettype wire

@@ src/apu_final.sv @@
`default_nettype none

module apu_final
    import apu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_s2         i_s2,
    output      logic        o_valid,
    output      logic [31:0] o_pixel
);

    logic        r_valid;
    logic [31:0] r_pixel;
    logic [31:0] n_pixel;
    logic [NUM_CHAN-1:0][7:0] chan;
    logic [NUM_CHAN-1:0][16:0] t_sum;
    logic [NUM_CHAN-1:0][16:0] t_fold;

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            // exact divide by 255 with rounding
            t_sum[k]  = 17'(i_s2.prod[k][15:0]) + ROUND_BIAS;
            t_fold[k] = t_sum[k] + (t_sum[k] >> 8);
            if (i_s2.op == OP_UNPREMUL) begin
                // saturate when the quotient exceeds 8 bits
                chan[k] = (i_s2.prod[k][31:24] != 8'h00) ? 8'hff : i_s2.prod[k][23:16];
            end else begin
                chan[k] = t_fold[k][15:8];
            end
        end
        if (i_s2.clear) begin
            n_pixel = '0;
        end else if (i_s2.pass) begin
            n_pixel = i_s2.pixel;
        end else begin
            n_pixel = {i_s2.pixel[31:24], chan[2], chan[1], chan[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

`default_nettype wire

@@ src/alpha_premultiply_unit_core.sv @@
`default_nettype none

// channel   dir  ports                          transfer when
// command   in   start, busy, i_opcode,         start && !busy
//                i_pixel_in
// result    out  o_valid, o_pixel_out           o_valid (one cycle, no hold-off)
//
// three register stages: reciprocal rom lookup, channel multiply, round/saturate
// o_valid rises once the pixel has been registered by the lookup, multiply and final stages
// one pixel per clock; the multiply stage (one 8 x 24 multiplier per channel) sets the clock
// busy stays low, the receiver cannot stall so nothing ever waits in the pipe
// synchronous active-low reset clears the stage valid bits only

module alpha_premultiply_unit_core
    import apu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic        i_opcode,
    input  wire logic [31:0] i_pixel_in,
    output      logic        o_valid,
    output      logic [31:0] o_pixel_out
);

    logic in_xfer;
    logic s1_valid;
    logic s2_valid;
    t_s1  s1;
    t_s2  s2;

    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    apu_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_xfer),
        .i_opcode(i_opcode),
        .i_pixel (i_pixel_in),
        .o_valid (s1_valid),
        .o_s1    (s1)
    );

    apu_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .o_s2    (s2)
    );

    apu_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_s2    (s2),
        .o_valid (o_valid),
        .o_pixel (o_pixel_out)
    );

    a_start_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ##3 o_valid)
        else $error("accepted pixel produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(in_xfer, 3))
        else $error("result without an accepted pixel");

    a_alpha_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_out[31:24] == $past(i_pixel_in[31:24], 3))
                    || (o_pixel_out == 32'h0))
        else $error("alpha changed on a non-cleared pixel");

    a_clear_only_premul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_pixel_out == 32'h0) && ($past(i_pixel_in, 3) != 32'h0))
        |-> ($past(i_opcode, 3) == OP_PREMUL))
        else $error("pixel cleared outside premultiply");

endmodule

`default_nettype wire
